@@ rtl/rln_pkg.sv @@
// Shared types and codes for the row layer normalizer.
`default_nettype none
package rln_pkg;

   // Packed stream layout widths
   localparam int unsigned REQ_DATA_W = 80;
   localparam int unsigned RSP_DATA_W = 32;
   localparam int unsigned EPS_W      = 20;
   localparam logic [EPS_W-1:0] EPS_RESET = 20'd42950;

   // Request kinds carried on tuser
   localparam logic CMD_LOAD      = 1'b0;
   localparam logic CMD_NORMALIZE = 1'b1;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_LOAD_MUL,
      OP_LOAD_ACC,
      OP_DIV1_INIT,
      OP_DIV_STEP,
      OP_DIV2_INIT,
      OP_M2,
      OP_VAR,
      OP_VEPS,
      OP_SQ,
      OP_PP,
      OP_ACC,
      OP_CMP,
      OP_STATS_DONE,
      OP_DIFF,
      OP_NMUL1,
      OP_NMUL2,
      OP_NMUL3,
      OP_NSUM,
      OP_NOFF,
      OP_EMIT
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic [4:0] bit_idx;
      logic [1:0] part;
   } dp_cmd_type;

   typedef struct packed {
      logic stats_ready;
      logic can_store;
      logic have_elem;
      logic out_busy;
      logic row_end;
   } dp_status_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_LOAD_MUL,
      ST_LOAD_ACC,
      ST_DIV1_INIT,
      ST_DIV1,
      ST_DIV2_INIT,
      ST_DIV2,
      ST_M2,
      ST_VAR,
      ST_VEPS,
      ST_SQ,
      ST_PP,
      ST_ACC,
      ST_CMP,
      ST_DONE,
      ST_DIFF,
      ST_NMUL1,
      ST_NMUL2,
      ST_NMUL3,
      ST_NSUM,
      ST_NOFF,
      ST_EMIT
   } ctrl_state_type;

endpackage
`default_nettype wire

@@ rtl/rln_ctrl.sv @@
// Sequencer for the row layer normalizer: handshake and step control.
`default_nettype none
module rln_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   input  wire                   req_cmd,
   input  wire                   req_row_end,
   output logic                  req_ready,
   input  rln_pkg::dp_status_type status,
   output rln_pkg::dp_cmd_type   cmd
);
   import rln_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic [5:0]     div_cnt_ff, div_cnt_in;
   logic [4:0]     bit_ff, bit_in;
   logic [1:0]     part_ff, part_in;
   logic           accept;

   assign accept = req_valid && (state_ff == ST_IDLE);

   always_comb begin
      state_in   = state_ff;
      div_cnt_in = div_cnt_ff;
      bit_in     = bit_ff;
      part_in    = part_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_cmd == CMD_LOAD) begin
                  if (status.stats_ready) state_in = ST_IDLE;
                  else if (status.can_store) state_in = ST_LOAD_MUL;
                  else if (req_row_end) state_in = ST_DIV1_INIT;
               end else if (status.stats_ready && status.have_elem) begin
                  state_in = ST_DIFF;
               end
            end
         end
         ST_LOAD_MUL: state_in = ST_LOAD_ACC;
         ST_LOAD_ACC: state_in = status.row_end ? ST_DIV1_INIT : ST_IDLE;
         ST_DIV1_INIT: begin
            div_cnt_in = '0;
            state_in   = ST_DIV1;
         end
         ST_DIV1: begin
            div_cnt_in = div_cnt_ff + 6'd1;
            if (div_cnt_ff == 6'd63) state_in = ST_DIV2_INIT;
         end
         ST_DIV2_INIT: begin
            div_cnt_in = '0;
            state_in   = ST_DIV2;
         end
         ST_DIV2: begin
            div_cnt_in = div_cnt_ff + 6'd1;
            if (div_cnt_ff == 6'd63) state_in = ST_M2;
         end
         ST_M2:   state_in = ST_VAR;
         ST_VAR:  state_in = ST_VEPS;
         ST_VEPS: begin
            bit_in   = 5'd31;
            state_in = ST_SQ;
         end
         ST_SQ: begin
            part_in  = '0;
            state_in = ST_PP;
         end
         ST_PP: state_in = ST_ACC;
         ST_ACC: begin
            part_in  = part_ff + 2'd1;
            state_in = (part_ff == 2'd3) ? ST_CMP : ST_PP;
         end
         ST_CMP: begin
            bit_in   = bit_ff - 5'd1;
            state_in = (bit_ff == 5'd0) ? ST_DONE : ST_SQ;
         end
         ST_DONE:  state_in = ST_IDLE;
         ST_DIFF:  state_in = ST_NMUL1;
         ST_NMUL1: state_in = ST_NMUL2;
         ST_NMUL2: state_in = ST_NMUL3;
         ST_NMUL3: state_in = ST_NSUM;
         ST_NSUM:  state_in = ST_NOFF;
         ST_NOFF:  state_in = ST_EMIT;
         ST_EMIT:  if (!status.out_busy) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready   = (state_ff == ST_IDLE);
      cmd.bit_idx = bit_ff;
      cmd.part    = part_ff;
      unique case (state_ff)
         ST_IDLE:      cmd.op = accept ? OP_ACCEPT : OP_NONE;
         ST_LOAD_MUL:  cmd.op = OP_LOAD_MUL;
         ST_LOAD_ACC:  cmd.op = OP_LOAD_ACC;
         ST_DIV1_INIT: cmd.op = OP_DIV1_INIT;
         ST_DIV1:      cmd.op = OP_DIV_STEP;
         ST_DIV2_INIT: cmd.op = OP_DIV2_INIT;
         ST_DIV2:      cmd.op = OP_DIV_STEP;
         ST_M2:        cmd.op = OP_M2;
         ST_VAR:       cmd.op = OP_VAR;
         ST_VEPS:      cmd.op = OP_VEPS;
         ST_SQ:        cmd.op = OP_SQ;
         ST_PP:        cmd.op = OP_PP;
         ST_ACC:       cmd.op = OP_ACC;
         ST_CMP:       cmd.op = OP_CMP;
         ST_DONE:      cmd.op = OP_STATS_DONE;
         ST_DIFF:      cmd.op = OP_DIFF;
         ST_NMUL1:     cmd.op = OP_NMUL1;
         ST_NMUL2:     cmd.op = OP_NMUL2;
         ST_NMUL3:     cmd.op = OP_NMUL3;
         ST_NSUM:      cmd.op = OP_NSUM;
         ST_NOFF:      cmd.op = OP_NOFF;
         ST_EMIT:      cmd.op = status.out_busy ? OP_NONE : OP_EMIT;
         default:      cmd.op = OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      div_cnt_ff <= div_cnt_in;
      bit_ff     <= bit_in;
      part_ff    <= part_in;
   end

endmodule
`default_nettype wire

@@ rtl/rln_datapath.sv @@
// Datapath for the row layer normalizer: row memory, sums, divider, root search, output.
`default_nettype none
module rln_datapath #(
   parameter int ROW_LEN = 768
) (
   input  wire                              clock,
   input  wire                              reset,
   input  rln_pkg::dp_cmd_type              cmd,
   output rln_pkg::dp_status_type           status,
   input  wire [rln_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  wire                              req_tlast,
   input  wire                              csr_we,
   input  wire [rln_pkg::EPS_W-1:0]         csr_wdata,
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   output logic [rln_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                             rsp_tlast,
   output logic                             rsp_tuser
);
   import rln_pkg::*;

   localparam int IDX_W  = $clog2(ROW_LEN + 1);
   localparam int ADDR_W = $clog2(ROW_LEN);
   localparam int SUM_W  = 33 + $clog2(ROW_LEN);
   localparam logic [IDX_W-1:0] ROW_LEN_I = IDX_W'(ROW_LEN);

   logic [31:0] row_mem [ROW_LEN];
   logic [31:0] rd_data_ff;

   // request payload
   logic [31:0] value_ff;
   logic [23:0] gain_ff, offset_ff;
   logic        row_end_ff;

   // row state
   logic signed [SUM_W-1:0] value_sum_ff, value_sum_in;
   logic [63:0]       square_sum_ff, square_sum_in;
   logic [IDX_W-1:0]  write_index_ff, write_index_in;
   logic [IDX_W-1:0]  read_index_ff, read_index_in;
   logic [31:0]       mean_ff, mean_in;
   logic [31:0]       inv_ff, inv_in;
   logic              stats_ready_ff, stats_ready_in;
   logic [EPS_W-1:0]  eps_ff, eps_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // work registers
   logic [63:0]       prod_ff, pp_ff, quot_ff, var_ff, v_ff;
   logic [IDX_W:0]    rem_ff;
   logic              div_neg_ff, neg_ff, clip_ff;
   logic [31:0]       y_ff, dm_ff, res_ff;
   logic [127:0]      acc_ff;
   logic [31:0]       rsp_data_ff;
   logic              rsp_last_ff, rsp_clip_ff;

   // combinational helpers
   logic [31:0]       mul_a, mul_b;
   logic [63:0]       mul_p;
   logic [31:0]       val_mag, mean_mag, cand;
   logic [23:0]       gain_mag;
   logic [IDX_W-1:0]  divisor;
   logic [IDX_W:0]    rem_sh;
   logic [SUM_W-1:0]  sum_mag;
   logic [64:0]       veps_sum;
   logic [127:0]      pp_shift;
   logic signed [32:0] diff;
   logic [91:0]       shifted;
   logic [34:0]       mag;
   logic signed [35:0] signed_mag, biased;
   logic [IDX_W-1:0]  read_next;
   logic              out_busy;

   assign out_busy = rsp_valid_ff && !rsp_tready;

   always_comb begin
      val_mag   = value_ff[31] ? (32'd0 - value_ff) : value_ff;
      mean_mag  = mean_ff[31] ? (32'd0 - mean_ff) : mean_ff;
      gain_mag  = gain_ff[23] ? (24'd0 - gain_ff) : gain_ff;
      cand      = y_ff | (32'd1 << cmd.bit_idx);
      divisor   = (write_index_ff == '0) ? IDX_W'(1) : write_index_ff;
      rem_sh    = {rem_ff[IDX_W-1:0], quot_ff[63]};
      sum_mag   = value_sum_ff[SUM_W-1] ? SUM_W'(-value_sum_ff) : SUM_W'(value_sum_ff);
      veps_sum  = {1'b0, var_ff} + {45'd0, eps_ff};
      diff      = $signed({rd_data_ff[31], rd_data_ff}) - $signed({mean_ff[31], mean_ff});
      shifted   = acc_ff[127:36];
      mag       = (shifted > 92'h4_0000_0000) ? 35'h4_0000_0000 : shifted[34:0];
      signed_mag = neg_ff ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      biased    = signed_mag + 36'($signed(offset_ff));
      read_next = read_index_ff + IDX_W'(1);
      case (cmd.part)
         2'd0:    pp_shift = {64'd0, pp_ff};
         2'd3:    pp_shift = {pp_ff, 64'd0};
         default: pp_shift = {32'd0, pp_ff, 32'd0};
      endcase
   end

   // shared 32x32 multiplier
   always_comb begin
      unique case (cmd.op)
         OP_LOAD_MUL: begin mul_a = val_mag;  mul_b = val_mag;  end
         OP_M2:       begin mul_a = mean_mag; mul_b = mean_mag; end
         OP_SQ:       begin mul_a = cand;     mul_b = cand;     end
         OP_PP: begin
            mul_a = cmd.part[0] ? prod_ff[63:32] : prod_ff[31:0];
            mul_b = cmd.part[1] ? v_ff[63:32] : v_ff[31:0];
         end
         OP_NMUL1:    begin mul_a = dm_ff; mul_b = inv_ff; end
         OP_NMUL2:    begin mul_a = prod_ff[31:0];  mul_b = {8'd0, gain_mag}; end
         OP_NMUL3:    begin mul_a = prod_ff[63:32]; mul_b = {8'd0, gain_mag}; end
         default:     begin mul_a = '0; mul_b = '0; end
      endcase
      mul_p = mul_a * mul_b;
   end

   always_comb begin
      value_sum_in   = value_sum_ff;
      square_sum_in  = square_sum_ff;
      write_index_in = write_index_ff;
      read_index_in  = read_index_ff;
      mean_in        = mean_ff;
      inv_in         = inv_ff;
      stats_ready_in = stats_ready_ff;
      eps_in         = csr_we ? csr_wdata : eps_ff;
      rsp_valid_in   = rsp_tready ? 1'b0 : rsp_valid_ff;
      case (cmd.op)
         OP_LOAD_ACC: begin
            value_sum_in   = value_sum_ff + SUM_W'($signed(value_ff));
            square_sum_in  = (square_sum_ff + prod_ff < square_sum_ff) ? '1
                                                                       : square_sum_ff + prod_ff;
            write_index_in = write_index_ff + IDX_W'(1);
         end
         OP_DIV2_INIT:  mean_in = div_neg_ff ? (32'd0 - quot_ff[31:0]) : quot_ff[31:0];
         OP_STATS_DONE: begin
            inv_in         = y_ff;
            stats_ready_in = 1'b1;
            read_index_in  = '0;
         end
         OP_EMIT: begin
            rsp_valid_in  = 1'b1;
            read_index_in = read_next;
            if (read_next >= write_index_ff) begin
               stats_ready_in = 1'b0;
               value_sum_in   = '0;
               square_sum_in  = '0;
               write_index_in = '0;
               read_index_in  = '0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_sum_ff   <= '0;
         square_sum_ff  <= '0;
         write_index_ff <= '0;
         read_index_ff  <= '0;
         mean_ff        <= '0;
         inv_ff         <= '0;
         stats_ready_ff <= 1'b0;
         eps_ff         <= EPS_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         value_sum_ff   <= value_sum_in;
         square_sum_ff  <= square_sum_in;
         write_index_ff <= write_index_in;
         read_index_ff  <= read_index_in;
         mean_ff        <= mean_in;
         inv_ff         <= inv_in;
         stats_ready_ff <= stats_ready_in;
         eps_ff         <= eps_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // row memory, registered read at the read pointer
   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD_MUL) row_mem[write_index_ff[ADDR_W-1:0]] <= value_ff;
      rd_data_ff <= row_mem[read_index_ff[ADDR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_ACCEPT: begin
            value_ff   <= req_tdata[31:0];
            gain_ff    <= req_tdata[55:32];
            offset_ff  <= req_tdata[79:56];
            row_end_ff <= req_tlast;
         end
         OP_LOAD_MUL, OP_M2, OP_SQ, OP_NMUL1: prod_ff <= mul_p;
         OP_DIV1_INIT: begin
            quot_ff    <= {{(64-SUM_W){1'b0}}, sum_mag};
            rem_ff     <= '0;
            div_neg_ff <= value_sum_ff[SUM_W-1];
         end
         OP_DIV_STEP: begin
            if (rem_sh >= {1'b0, divisor}) begin
               rem_ff  <= rem_sh - {1'b0, divisor};
               quot_ff <= {quot_ff[62:0], 1'b1};
            end else begin
               rem_ff  <= rem_sh;
               quot_ff <= {quot_ff[62:0], 1'b0};
            end
         end
         OP_DIV2_INIT: begin
            quot_ff <= square_sum_ff;
            rem_ff  <= '0;
         end
         OP_VAR:  var_ff <= (quot_ff > prod_ff) ? quot_ff - prod_ff : 64'd0;
         OP_VEPS: begin
            v_ff <= veps_sum[64] ? '1 : veps_sum[63:0];
            y_ff <= '0;
         end
         OP_PP:   pp_ff <= mul_p;
         OP_ACC:  acc_ff <= ((cmd.part == 2'd0) ? 128'd0 : acc_ff) + pp_shift;
         OP_CMP: begin
            if (acc_ff[127:64] < 64'd256 || (acc_ff[127:64] == 64'd256 && acc_ff[63:0] == '0))
               y_ff <= cand;
         end
         OP_DIFF: begin
            dm_ff  <= diff[32] ? 32'(-diff) : diff[31:0];
            neg_ff <= diff[32] ^ gain_ff[23];
         end
         OP_NMUL2: pp_ff <= mul_p;
         OP_NMUL3: begin
            acc_ff <= {64'd0, pp_ff};
            pp_ff  <= mul_p;
         end
         OP_NSUM: acc_ff <= acc_ff + {32'd0, pp_ff, 32'd0};
         OP_NOFF: begin
            if (biased > 36'sh0_7FFF_FFFF) begin
               res_ff  <= 32'h7FFF_FFFF;
               clip_ff <= 1'b1;
            end else if (biased < -36'sh0_8000_0000) begin
               res_ff  <= 32'h8000_0000;
               clip_ff <= 1'b1;
            end else begin
               res_ff  <= biased[31:0];
               clip_ff <= 1'b0;
            end
         end
         OP_EMIT: begin
            rsp_data_ff <= res_ff;
            rsp_last_ff <= (read_next >= write_index_ff);
            rsp_clip_ff <= clip_ff;
         end
         default: ;
      endcase
   end

   assign status.stats_ready = stats_ready_ff;
   assign status.can_store   = (write_index_ff < ROW_LEN_I);
   assign status.have_elem   = (read_index_ff < write_index_ff);
   assign status.out_busy    = out_busy;
   assign status.row_end     = row_end_ff;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_clip_ff;

endmodule
`default_nettype wire

@@ rtl/row_layer_normalizer.sv @@
// Top level of the row layer normalizer: controller, datapath and checks.
`default_nettype none
// Fixed-point layer normalization, one row at a time. Load requests (tuser 0)
// store a Q16.16 value and accumulate sum and sum of squares. The load
// flagged tlast closes the row: mean and mean square come from a
// one-bit-per-cycle divider, then a 32-step bit search finds the inverse
// root with the single shared 32x32 multiplier. Normalize requests (tuser 1)
// carry gain and offset and return one result each, in stored order, each
// waiting as needed on the response register. Loads arriving during
// normalize and normalizes arriving during load are dropped. Epsilon
// (2^-32 units) is written through csr_we/csr_wdata; the user must write it
// only while idle, as the block itself does not enforce this.
module row_layer_normalizer #(
   parameter int ROW_LEN = 768
) (
   input  wire         clock,
   input  wire         reset,
   // request stream
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire [79:0]  req_tdata,  // value[31:0], gain[55:32], offset[79:56]
   input  wire         req_tlast,  // row_end
   input  wire         req_tuser,  // cmd: 0 load, 1 normalize
   // response stream
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [31:0] rsp_tdata,  // normalized[31:0]
   output logic        rsp_tlast,  // last element of row
   output logic        rsp_tuser,  // clipped
   // epsilon register
   input  wire         csr_we,
   input  wire [19:0]  csr_wdata
);
   import rln_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   rln_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_cmd     (req_tuser),
      .req_row_end (req_tlast),
      .req_ready   (req_tready),
      .status      (dp_status),
      .cmd         (dp_cmd)
   );

   rln_datapath #(.ROW_LEN(ROW_LEN)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (dp_cmd),
      .status     (dp_status),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // response register is never overwritten while a result is stalled
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.op == OP_EMIT |-> !(rsp_tvalid && !rsp_tready))
      else $error("emit into stalled response");

   // closing the stats enters the normalize phase
   a_stats_on: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.op == OP_STATS_DONE |=> dp_status.stats_ready)
      else $error("stats not ready after finish");

   // an emit with no element left to read never occurs while stats are ready
   a_row_drained: assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.op == OP_EMIT && !dp_status.have_elem) |-> !dp_status.stats_ready)
      else $error("emit with no element while ready");

endmodule
`default_nettype wire
